// ----- src/pxo_pkg.sv -----
package pxo_pkg;

	localparam int MAX_LENGTH = 64;
	localparam int GENE_W     = 6;
	localparam int CFG_W      = 7;
	localparam int GENES      = 1 << GENE_W;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int POS_W      = $clog2(MAX_LENGTH);

	// controller to datapath
	typedef struct packed {
		logic load;      // input request taken this cycle
		logic put_gene;  // write parent B gene at fill position, advance fill pointer
		logic put_zero;  // fill exhausted: write zero and flag the run
		logic fp_inc;    // skip a seen parent B entry
		logic p_next;    // advance (or wrap) the walk position
	} pxo_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic load_last;
		logic child_empty;
		logic fp_done;
		logic b_seen;
		logic p_last;
	} pxo_sts_t;

endpackage

// ----- src/pxo_datapath.sv -----
module pxo_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [pxo_pkg::CFG_W-1:0]   cfg_data,
	input  pxo_pkg::pxo_cmd_t           cmd,
	output pxo_pkg::pxo_sts_t           sts,
	input  logic [pxo_pkg::GENE_W-1:0]  parent_a_gene,
	input  logic [pxo_pkg::GENE_W-1:0]  parent_b_gene,
	input  logic [pxo_pkg::GENE_W-1:0]  cut_point,
	output logic [pxo_pkg::GENE_W-1:0]  child_gene,
	output logic                        invalid_parents
);

	logic [pxo_pkg::CFG_W-1:0]  len_cfg_q;
	logic [pxo_pkg::CNT_W-1:0]  len;
	logic [pxo_pkg::CNT_W-1:0]  pos_q;
	logic [pxo_pkg::CNT_W-1:0]  p_q;
	logic [pxo_pkg::CNT_W-1:0]  fp_q;
	logic [pxo_pkg::GENE_W-1:0] cut_q;
	logic [pxo_pkg::GENES-1:0]  seen_q;
	logic                       bad_q;

	logic                       first;
	logic [pxo_pkg::GENE_W-1:0] cut_now;
	logic                       below_cut;
	logic [pxo_pkg::GENES-1:0]  seen_base;
	logic                       b_was_seen;
	logic [pxo_pkg::GENES-1:0]  mark;
	logic [pxo_pkg::GENE_W:0]   load_val;

	logic [pxo_pkg::GENE_W:0]   child_mem [pxo_pkg::MAX_LENGTH];
	logic [pxo_pkg::GENE_W-1:0] pb_mem    [pxo_pkg::MAX_LENGTH];
	logic [pxo_pkg::GENE_W:0]   child_rd_q;
	logic [pxo_pkg::GENE_W-1:0] pb_rd_q;
	logic                       wr_en;
	logic [pxo_pkg::POS_W-1:0]  wr_addr;
	logic [pxo_pkg::GENE_W:0]   wr_data;

	// saturate length to 1..MAX_LENGTH
	always_comb begin
		if (len_cfg_q == '0) begin
			len = pxo_pkg::CNT_W'(1);
		end else if (len_cfg_q > pxo_pkg::CFG_W'(pxo_pkg::MAX_LENGTH)) begin
			len = pxo_pkg::CNT_W'(pxo_pkg::MAX_LENGTH);
		end else begin
			len = pxo_pkg::CNT_W'(len_cfg_q);
		end
	end

	assign first      = (pos_q == '0);
	assign cut_now    = first ? cut_point : cut_q;
	assign below_cut  = pos_q < pxo_pkg::CNT_W'(cut_now);
	// the map reads as clear on the first position of a run
	assign seen_base  = first ? '0 : seen_q;
	assign b_was_seen = seen_base[parent_b_gene];

	always_comb begin
		if (below_cut) begin
			mark     = pxo_pkg::GENES'(1) << parent_a_gene;
			load_val = {1'b0, parent_a_gene};
		end else if (!b_was_seen) begin
			mark     = pxo_pkg::GENES'(1) << parent_b_gene;
			load_val = {1'b0, parent_b_gene};
		end else begin
			mark     = '0;
			load_val = {1'b1, {pxo_pkg::GENE_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= pxo_pkg::CFG_W'(pxo_pkg::MAX_LENGTH);
			pos_q     <= '0;
			p_q       <= '0;
			fp_q      <= '0;
			cut_q     <= '0;
			seen_q    <= '0;
			bad_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_cfg_q <= cfg_data;
			end
			if (cmd.load) begin
				seen_q <= seen_base | mark;
				if (first) begin
					cut_q <= cut_point;
				end
				if (sts.load_last) begin
					pos_q <= '0;
					p_q   <= '0;
					fp_q  <= '0;
					bad_q <= 1'b0;
				end else begin
					pos_q <= pos_q + pxo_pkg::CNT_W'(1);
				end
			end
			if (cmd.put_gene) begin
				seen_q[pb_rd_q] <= 1'b1;
			end
			if (cmd.put_gene || cmd.fp_inc) begin
				fp_q <= fp_q + pxo_pkg::CNT_W'(1);
			end
			if (cmd.put_zero) begin
				bad_q <= 1'b1;
			end
			if (cmd.p_next) begin
				p_q <= sts.p_last ? '0 : p_q + pxo_pkg::CNT_W'(1);
			end
		end
	end

	assign wr_en   = cmd.load || cmd.put_gene || cmd.put_zero;
	assign wr_addr = cmd.load ? pos_q[pxo_pkg::POS_W-1:0] : p_q[pxo_pkg::POS_W-1:0];

	always_comb begin
		if (cmd.load) begin
			wr_data = load_val;
		end else if (cmd.put_gene) begin
			wr_data = {1'b0, pb_rd_q};
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			child_mem[wr_addr] <= wr_data;
		end
		child_rd_q <= child_mem[p_q[pxo_pkg::POS_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pb_mem[pos_q[pxo_pkg::POS_W-1:0]] <= parent_b_gene;
		end
		pb_rd_q <= pb_mem[fp_q[pxo_pkg::POS_W-1:0]];
	end

	assign sts.load_last   = (pos_q + pxo_pkg::CNT_W'(1)) >= len;
	assign sts.p_last      = (p_q + pxo_pkg::CNT_W'(1)) >= len;
	assign sts.fp_done     = fp_q >= len;
	assign sts.child_empty = child_rd_q[pxo_pkg::GENE_W];
	assign sts.b_seen      = seen_q[pb_rd_q];

	assign child_gene      = child_rd_q[pxo_pkg::GENE_W-1:0];
	assign invalid_parents = bad_q;

endmodule

// ----- src/pxo_ctrl.sv -----
module pxo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pxo_pkg::pxo_sts_t  sts,
	output pxo_pkg::pxo_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_FILL_RD,
		S_FILL_CHK,
		S_FIND_RD,
		S_FIND_CHK,
		S_EMIT_RD,
		S_EMIT_SHOW
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_EMIT_SHOW);

	always_comb begin
		cmd      = '0;
		cmd.load = in_ready && in_valid;
		unique case (state_q)
			S_FILL_CHK: begin
				if (!sts.child_empty) begin
					cmd.p_next = 1'b1;
				end else if (sts.fp_done) begin
					cmd.put_zero = 1'b1;
					cmd.p_next   = 1'b1;
				end
			end
			S_FIND_CHK: begin
				if (sts.b_seen) begin
					cmd.fp_inc = 1'b1;
				end else begin
					cmd.put_gene = 1'b1;
					cmd.p_next   = 1'b1;
				end
			end
			S_EMIT_SHOW: begin
				cmd.p_next = out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (cmd.load && sts.load_last) begin
						state_q <= S_FILL_RD;
					end
				end
				S_FILL_RD: begin
					state_q <= S_FILL_CHK;
				end
				S_FILL_CHK: begin
					if (sts.child_empty && !sts.fp_done) begin
						state_q <= S_FIND_RD;
					end else begin
						state_q <= sts.p_last ? S_EMIT_RD : S_FILL_RD;
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CHK;
				end
				S_FIND_CHK: begin
					// seen entry: recheck the same position with the next pointer
					if (sts.b_seen) begin
						state_q <= S_FILL_CHK;
					end else begin
						state_q <= sts.p_last ? S_EMIT_RD : S_FILL_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_SHOW;
				end
				S_EMIT_SHOW: begin
					if (out_ready) begin
						state_q <= sts.p_last ? S_LOAD : S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output requests open together");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.p_last) |=> in_ready)
		else $error("no return to loading after final result");

	a_load_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && sts.load_last) |=> !in_ready)
		else $error("input still taken after final position");

	a_put_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_gene |-> (!sts.fp_done && !sts.b_seen && sts.child_empty))
		else $error("fill wrote a seen or exhausted gene");

endmodule

// ----- src/permutation_crossover_core.sv -----
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: parent_a, parent_b, cut
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: child; tlast; tuser: invalid
// cfg       in   cfg_valid / cfg_ready           cfg_data: chromosome_length
//
// Loading accepts one request per cycle, one per position.
// After the last position the fill walk reads, then checks, each position; an empty
// position that takes a parent B gene also reads and checks parent B, once more for each
// seen parent B entry skipped; both stores have one registered read port.
// Emission then reads and then shows each result; a stall holds the result.
// The length is taken only while loading; reset clears the seen map and counters at once.
module permutation_crossover_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,  // parent_a_gene, parent_b_gene, cut_point
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,  // child_gene
	output logic                      m_axis_tlast,
	output logic                      m_axis_tuser,  // invalid_parents
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pxo_pkg::CFG_W-1:0] cfg_data
);

	pxo_pkg::pxo_cmd_t          cmd;
	pxo_pkg::pxo_sts_t          sts;
	logic [pxo_pkg::GENE_W-1:0] child_gene;

	// hold length writes off while the fill walk and emission run
	assign cfg_ready = s_axis_tready;

	pxo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pxo_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.parent_a_gene   (s_axis_tdata[5:0]),
		.parent_b_gene   (s_axis_tdata[11:6]),
		.cut_point       (s_axis_tdata[17:12]),
		.child_gene      (child_gene),
		.invalid_parents (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, child_gene};
	assign m_axis_tlast = sts.p_last;

endmodule
